@@ rtl/core/pgmh_pkg.sv @@
// Shared types and constants for the PGM header parser and pixel histogram.
package pgmh_pkg;

    localparam int NumBinsDefault   = 256;
    localparam int CountBitsDefault = 32;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_WIDTH  = 3'd1;
    localparam logic [2:0] PH_HEIGHT = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_PIXELS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_BAD    = 3'd6;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [2:0] SKIP_LAST = 3'd3;

    // Operation passed from the parser to the histogram unit.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_COUNT = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  bin;
        logic [2:0]  phase;
        logic [15:0] width;
        logic [15:0] height;
    } t_cmd;

endpackage

@@ rtl/core/pgm_header_and_pixel_histogram.sv @@
// Top level: PGM header parser and 256-bin pixel histogram on stream ports.
//  channel | dir | tdata bits (low first)                     | tuser
//  s_axis  | in  | byte_value[7:0], bin_index[15:8]           | kind[1:0]
//  m_axis  | out | phase[2:0] width[18:3] height[34:19]       | -
//          |     | bin_value[66:35] pixel_counted[67]         |
// Each request passes through the histogram unit's memory read, update and
// result steps, and the unit takes no new request until its result is taken.
// After reset and after each start request the unit clears the whole bin
// memory and takes no request during the sweep. A two-entry queue lets
// the parser take requests while the histogram unit is stalled.
module pgm_header_and_pixel_histogram import pgmh_pkg::*; #(
    parameter int NUM_BINS   = NumBinsDefault,
    parameter int COUNT_BITS = CountBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // byte_value, bin_index
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // phase, width, height, bin_value, pixel_counted
);

    logic f_valid, f_ready, q_valid, q_ready;
    t_cmd f_cmd, q_cmd;

    pgmh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_byte(s_axis_tdata[7:0]),
        .i_index(s_axis_tdata[15:8]),
        .o_cmd_valid(f_valid), .i_cmd_ready(f_ready), .o_cmd(f_cmd)
    );

    pgmh_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_cmd)
    );

    pgmh_back #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );

endmodule

@@ rtl/core/pgmh_front.sv @@
// Header parser: classifies each request and tracks the PGM header phase.
module pgmh_front import pgmh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_index,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);

    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] r_remain, n_remain;
    logic [31:0] w_prod;
    logic [19:0] w_acc10;
    logic [3:0]  w_digit;
    logic        w_fire;
    t_op         w_op;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign w_fire      = i_valid && i_cmd_ready;
    assign w_prod      = r_width * r_height;
    assign w_digit     = (i_byte >= CH_ZERO && i_byte <= CH_NINE) ?
                         4'(i_byte - CH_ZERO) : 4'd0;
    assign w_acc10     = 20'(r_acc) * 20'd10 + 20'(w_digit);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_width  = r_width;
        n_height = r_height;
        n_remain = r_remain;
        w_op     = OP_NONE;
        case (i_kind)
            KIND_START: begin
                n_phase = PH_MAGIC; n_pos = '0; n_acc = '0;
                n_width = '0; n_height = '0; n_remain = '0;
                w_op = OP_CLEAR;
            end
            KIND_READ: w_op = OP_READ;
            KIND_BYTE: begin
                unique case (r_phase)
                    PH_MAGIC: begin
                        if (r_pos == 3'd0) begin
                            if (i_byte != CH_P) n_phase = PH_BAD;
                            else n_pos = 3'd1;
                        end else if (r_pos == 3'd1) begin
                            if (i_byte != CH_5) n_phase = PH_BAD;
                            else n_pos = 3'd2;
                        end else begin
                            n_pos = '0; n_acc = '0; n_phase = PH_WIDTH;
                        end
                    end
                    PH_WIDTH, PH_HEIGHT: begin
                        if (r_phase == PH_WIDTH && i_byte == CH_SPACE) begin
                            n_width = r_acc; n_acc = '0; n_phase = PH_HEIGHT;
                        end else if (r_phase == PH_HEIGHT && i_byte == CH_LF) begin
                            n_height = r_acc; n_acc = '0; n_pos = '0;
                            n_phase = PH_SKIP;
                        end else begin
                            n_acc = (w_acc10 > 20'd65535) ? 16'hFFFF : w_acc10[15:0];
                        end
                    end
                    PH_SKIP: begin
                        if (r_pos >= SKIP_LAST) begin
                            n_pos = '0; n_remain = w_prod;
                            n_phase = (w_prod == '0) ? PH_DONE : PH_PIXELS;
                        end else begin
                            n_pos = r_pos + 3'd1;
                        end
                    end
                    PH_PIXELS: begin
                        w_op = OP_COUNT;
                        n_remain = r_remain - 32'd1;
                        if (n_remain == '0) n_phase = PH_DONE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        o_cmd.op     = w_op;
        o_cmd.bin    = (i_kind == KIND_READ) ? i_index : i_byte;
        o_cmd.phase  = n_phase;
        o_cmd.width  = n_width;
        o_cmd.height = n_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_pos <= '0; r_acc <= '0;
            r_width <= '0; r_height <= '0; r_remain <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase; r_pos <= n_pos; r_acc <= n_acc;
            r_width <= n_width; r_height <= n_height; r_remain <= n_remain;
        end
    end

endmodule

@@ rtl/core/pgmh_fifo.sv @@
// Two-entry queue between the parser and the histogram unit.
module pgmh_fifo import pgmh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_data
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

@@ rtl/core/pgmh_back.sv @@
// Histogram unit: bin memory with clear sweep, saturating count and read.
module pgmh_back import pgmh_pkg::*; #(
    parameter int NUM_BINS   = NumBinsDefault,
    parameter int COUNT_BITS = CountBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [71:0] o_data
);

    localparam int AW = $clog2(NUM_BINS);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WORK  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    logic [COUNT_BITS-1:0] r_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [AW:0]           r_clr;
    t_state                r_state;
    t_cmd                  r_cmd;
    logic [71:0]           r_out;
    logic [31:0]           w_val;
    logic                  w_take;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr[AW-1:0]] <= '0;
        end else if (r_state == S_WORK && r_cmd.op == OP_COUNT
                     && r_rdata != '1) begin
            r_mem[r_cmd.bin[AW-1:0]] <= r_rdata + 1'b1;
        end
        if (w_take) r_rdata <= r_mem[i_cmd.bin[AW-1:0]];
        if (w_take) r_cmd <= i_cmd;
    end

    always_comb begin
        w_val = '0;
        if (r_cmd.op == OP_READ) begin
            w_val = 32'(r_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(NUM_BINS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (w_take) r_state <= S_WORK;
                S_WORK: begin
                    r_out <= {4'd0, (r_cmd.op == OP_COUNT), w_val,
                              r_cmd.height, r_cmd.width, r_cmd.phase};
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) begin
                    // start a clear sweep after a start request has reported
                    if (r_cmd.op == OP_CLEAR) begin
                        r_clr <= '0; r_state <= S_CLEAR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

endmodule

@@ verif/tb_pgm_header_and_pixel_histogram.sv @@
// Self-checking testbench for the PGM header parser and pixel histogram.
module tb_pgm_header_and_pixel_histogram;
    import pgmh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // fields from the lowest bit up: phase, width, height, bin_value, counted
    typedef struct packed {
        logic        counted;
        logic [31:0] bin_value;
        logic [15:0] height;
        logic [15:0] width;
        logic [2:0]  phase;
    } t_status;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [7:0] bin_index;
        logic       has_exp;
        t_status    exp_status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;  // byte_value, bin_index
    logic [1:0]  s_axis_tuser;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;  // phase, width, height, bin_value, pixel_counted

    pgm_header_and_pixel_histogram dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic [2:0]  pr_phase;
    logic [2:0]  pr_pos;
    logic [15:0] pr_acc;
    logic [15:0] pr_width;
    logic [15:0] pr_height;
    logic [31:0] pr_left;
    logic [31:0] pr_bins [256];

    t_status expected_status_q[$];
    t_row    rows[$];
    int      n_errors;
    int      idle_cycles;
    bit      stim_done;

    function automatic void clear_image();
        pr_phase = PH_MAGIC;
        pr_pos = 0;
        pr_acc = 0;
        pr_width = 0;
        pr_height = 0;
        pr_left = 0;
        foreach (pr_bins[i]) pr_bins[i] = 0;
    endfunction

    function automatic void add_digit(input logic [7:0] b);
        int unsigned d;
        int unsigned v;
        d = (b >= CH_ZERO && b <= CH_NINE) ? int'(b - CH_ZERO) : 0;
        v = pr_acc * 10 + d;
        pr_acc = (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_status predict_status(input logic [1:0] kind, input logic [7:0] b,
                                               input logic [7:0] idx);
        t_status s;
        s = '0;
        if (kind == KIND_BYTE) begin
            case (pr_phase)
                PH_MAGIC: begin
                    if (pr_pos == 0) begin
                        if (b != CH_P) pr_phase = PH_BAD;
                        else pr_pos = 1;
                    end else if (pr_pos == 1) begin
                        if (b != CH_5) pr_phase = PH_BAD;
                        else pr_pos = 2;
                    end else begin
                        pr_pos = 0;
                        pr_acc = 0;
                        pr_phase = PH_WIDTH;
                    end
                end
                PH_WIDTH: begin
                    if (b == CH_SPACE) begin
                        pr_width = pr_acc;
                        pr_acc = 0;
                        pr_phase = PH_HEIGHT;
                    end else add_digit(b);
                end
                PH_HEIGHT: begin
                    if (b == CH_LF) begin
                        pr_height = pr_acc;
                        pr_acc = 0;
                        pr_pos = 0;
                        pr_phase = PH_SKIP;
                    end else add_digit(b);
                end
                PH_SKIP: begin
                    if (pr_pos >= SKIP_LAST) begin
                        pr_pos = 0;
                        pr_left = pr_width * pr_height;
                        pr_phase = (pr_left == 0) ? PH_DONE : PH_PIXELS;
                    end else pr_pos = pr_pos + 3'd1;
                end
                PH_PIXELS: begin
                    if (pr_bins[b] != 32'hFFFF_FFFF) pr_bins[b] = pr_bins[b] + 1;
                    s.counted = 1'b1;
                    pr_left = pr_left - 1;
                    if (pr_left == 0) pr_phase = PH_DONE;
                end
                default: ;
            endcase
        end else if (kind == KIND_READ) begin
            s.bin_value = pr_bins[idx];
        end else if (kind == KIND_START) begin
            clear_image();
        end
        s.phase = pr_phase;
        s.width = pr_width;
        s.height = pr_height;
        return s;
    endfunction

    function automatic void push_row(input logic [1:0] k, input logic [7:0] b,
                                     input logic [7:0] idx);
        t_row r;
        r.kind = k;
        r.byte_value = b;
        r.bin_index = idx;
        r.has_exp = 1'b0;
        r.exp_status = '0;
        rows.push_back(r);
    endfunction

    function automatic void push_fixed(input logic [1:0] k, input logic [7:0] b,
                                       input logic [7:0] idx, input t_status s);
        t_row r;
        r.kind = k;
        r.byte_value = b;
        r.bin_index = idx;
        r.has_exp = 1'b1;
        r.exp_status = s;
        rows.push_back(r);
    endfunction

    function automatic void push_text(input string txt);
        foreach (txt[i]) push_row(KIND_BYTE, txt[i], 8'($urandom));
    endfunction

    function automatic string rand_number();
        string s;
        int n;
        n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 2);
        s = "";
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) s = {s, string'(byte'($urandom_range(33, 126)))};
            else s = {s, string'(byte'($urandom_range(48, 57)))};
        end
        return s;
    endfunction

    // a well formed file (mostly), random size and pixels, with reads
    function automatic void push_random_file();
        string hdr;
        int npix;
        push_row(KIND_START, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            push_row(KIND_BYTE, 8'($urandom), 8'($urandom));
            push_row(KIND_BYTE, 8'($urandom), 8'($urandom));
        end else begin
            hdr = {"P5", string'(byte'($urandom)), rand_number(), " ", rand_number(), "\n"};
            push_text(hdr);
            for (int i = 0; i < 4; i++) push_row(KIND_BYTE, 8'($urandom), 8'($urandom));
        end
        npix = $urandom_range(0, 40);
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 5) == 0) push_row(KIND_READ, 8'($urandom), 8'($urandom));
            else if ($urandom_range(0, 3) == 0)
                push_row(KIND_BYTE, 8'($urandom_range(0, 3)), 8'd0);
            else push_row(KIND_BYTE, 8'($urandom), 8'($urandom));
        end
        for (int i = 0; i < 4; i++)
            push_row(KIND_READ, 8'($urandom), 8'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) == 0) push_row(KIND_OTHER, 8'($urandom), 8'($urandom));
    endfunction

    function automatic t_status st(input logic [2:0] ph, input logic [15:0] w,
                                   input logic [15:0] h, input logic [31:0] v,
                                   input logic c);
        t_status s;
        s.phase = ph;
        s.width = w;
        s.height = h;
        s.bin_value = v;
        s.counted = c;
        return s;
    endfunction

    function automatic void build_directed();
        push_fixed(KIND_READ, 8'h00, 8'hFF, st(PH_MAGIC, 0, 0, 0, 0));
        push_fixed(KIND_BYTE, 8'hFF, 8'h00, st(PH_BAD, 0, 0, 0, 0));
        push_fixed(KIND_BYTE, CH_P, 8'h00, st(PH_BAD, 0, 0, 0, 0));
        push_fixed(KIND_START, 8'h00, 8'h00, st(PH_MAGIC, 0, 0, 0, 0));
        push_row(KIND_BYTE, CH_P, 0);
        push_fixed(KIND_BYTE, 8'h36, 8'h00, st(PH_BAD, 0, 0, 0, 0));
        push_row(KIND_START, 0, 0);
        // saturating width and a non-digit in height
        push_text("P5 999999 1x\n");
        push_text("2551");
        push_row(KIND_START, 0, 0);
        push_text("P5\n2 1\n255\n");
        push_row(KIND_BYTE, 8'h00, 0);
        push_row(KIND_BYTE, 8'hFF, 0);
        push_row(KIND_BYTE, 8'h00, 0);
        push_row(KIND_READ, 0, 8'hFF);
        push_row(KIND_OTHER, 8'hFF, 8'hFF);
        push_row(KIND_START, 0, 0);
        // empty width: zero pixels, straight to done
        push_text("P5  3\n255 ");
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // source: table rows then random files
    initial begin
        t_row r;
        int   gap;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        stim_done = 1'b0;
        gap = 0;
        clear_image();
        build_directed();
        while (rows.size() < 1000) push_random_file();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[n]) begin
            r = rows[n];
            if (gap > 0) repeat (gap) @(posedge i_clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= r.kind;
            s_axis_tdata <= {r.bin_index, r.byte_value};
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            if (r.has_exp) begin
                void'(predict_status(r.kind, r.byte_value, r.bin_index));
                expected_status_q.push_back(r.exp_status);
            end else begin
                expected_status_q.push_back(predict_status(r.kind, r.byte_value, r.bin_index));
            end
            gap = 0;
            if (n >= 30 && $urandom_range(0, 3) == 0)
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : 1;
            // lower valid only after the last row or when the next row is held back
            if (n == rows.size() - 1 || gap > 0) s_axis_tvalid <= 1'b0;
        end
        stim_done = 1'b1;
    end

    // sink: random back-pressure, checks each result
    initial begin
        t_status got;
        t_status want;
        int      hold;
        n_errors = 0;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[67:0];
                if (expected_status_q.size() == 0) begin
                    $display("%0t unexpected result %h", $realtime, got);
                    n_errors++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch: expected ph=%0d w=%0d h=%0d bin=%0d c=%0d, ",
                                 $realtime, want.phase, want.width, want.height,
                                 want.bin_value, want.counted,
                                 "actual ph=%0d w=%0d h=%0d bin=%0d c=%0d",
                                 got.phase, got.width, got.height, got.bin_value, got.counted);
                        n_errors++;
                    end
                end
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 199) == 0) begin
                hold = $urandom_range(5, 30);
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 40) == 0) m_axis_tready <= 1'b0;
            else if ($urandom_range(0, 2) == 0) m_axis_tready <= ($urandom_range(0, 1) == 0);
            else m_axis_tready <= 1'b1;
        end
    end

    // watchdog and end of run
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else idle_cycles++;
            if (stim_done && expected_status_q.size() == 0) begin
                repeat (20) @(posedge i_clk);
                if (n_errors == 0 && expected_status_q.size() == 0)
                    $display("end of test: clean");
                else
                    $display("end of test: mismatches");
                $finish;
            end else if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
